[rtl/rp2y_pkg.sv]
package rp2y_pkg;

  // pixel component and fixed-point arithmetic widths
  localparam int unsigned PixelWidth = 8;
  localparam int unsigned CoefWidth  = 16;
  localparam int unsigned ProdWidth  = CoefWidth + PixelWidth + 1;
  localparam int unsigned SumWidth   = ProdWidth + 2;
  localparam int unsigned QShift     = 15;
  localparam int unsigned ScaledWidth = SumWidth - QShift;

  typedef logic [PixelWidth-1:0]       pixel_t;
  typedef logic signed [CoefWidth-1:0] coef_t;
  typedef logic signed [ProdWidth-1:0] prod_t;
  typedef logic signed [SumWidth-1:0]  sum_t;
  typedef logic signed [ScaledWidth-1:0] scaled_t;

  // weights of one color conversion row, in Q15
  typedef struct packed {
    coef_t red;
    coef_t green;
    coef_t blue;
  } coef_row_t;

  // bt.601 rows
  localparam coef_row_t LumaRow = '{red: 16'sd9798, green: 16'sd19235, blue: 16'sd3736};
  localparam coef_row_t URow    = '{red: -16'sd5505, green: -16'sd10879, blue: 16'sd16384};
  localparam coef_row_t VRow    = '{red: 16'sd16384, green: -16'sd13730, blue: -16'sd2654};

  // offsets added after scaling
  localparam scaled_t LumaOffset   = scaled_t'(0);
  localparam scaled_t ChromaOffset = scaled_t'(128);

  localparam scaled_t ByteMax = scaled_t'(255);

  // floor shift by 15, add offset, clip to one byte
  function automatic pixel_t to_byte(sum_t s, scaled_t offset);
    scaled_t q;
    q = s[SumWidth-1:QShift] + offset;
    if (q < 0) begin
      return '0;
    end else if (q > ByteMax) begin
      return '1;
    end
    return q[PixelWidth-1:0];
  endfunction

endpackage

[rtl/rp2y_lane.sv]
module rp2y_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  rp2y_pkg::pixel_t   red_i,
  input  rp2y_pkg::pixel_t   green_i,
  input  rp2y_pkg::pixel_t   blue_i,
  input  rp2y_pkg::coef_row_t chroma_row_i,
  output rp2y_pkg::sum_t     luma_sum_o,
  output rp2y_pkg::sum_t     chroma_sum_o
);

  logic signed [rp2y_pkg::PixelWidth:0] red_s, green_s, blue_s;

  rp2y_pkg::prod_t y_red_q, y_green_q, y_blue_q;
  rp2y_pkg::prod_t c_red_q, c_green_q, c_blue_q;

  // components as non-negative signed operands
  assign red_s   = $signed({1'b0, red_i});
  assign green_s = $signed({1'b0, green_i});
  assign blue_s  = $signed({1'b0, blue_i});

  // product registers for luma and this lane's chroma row
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_red_q   <= rp2y_pkg::LumaRow.red * red_s;
      y_green_q <= rp2y_pkg::LumaRow.green * green_s;
      y_blue_q  <= rp2y_pkg::LumaRow.blue * blue_s;
      c_red_q   <= chroma_row_i.red * red_s;
      c_green_q <= chroma_row_i.green * green_s;
      c_blue_q  <= chroma_row_i.blue * blue_s;
    end
  end

  // weighted sums
  assign luma_sum_o = rp2y_pkg::sum_t'(y_red_q) + rp2y_pkg::sum_t'(y_green_q)
                    + rp2y_pkg::sum_t'(y_blue_q);
  assign chroma_sum_o = rp2y_pkg::sum_t'(c_red_q) + rp2y_pkg::sum_t'(c_green_q)
                      + rp2y_pkg::sum_t'(c_blue_q);

endmodule

[rtl/rp2y_merge.sv]
module rp2y_merge (
  input  logic             clk_i,
  input  logic             en_i,
  input  rp2y_pkg::sum_t   luma_first_sum_i,
  input  rp2y_pkg::sum_t   chroma_blue_sum_i,
  input  rp2y_pkg::sum_t   luma_second_sum_i,
  input  rp2y_pkg::sum_t   chroma_red_sum_i,
  input  logic             line_end_i,
  output rp2y_pkg::pixel_t luma_first_o,
  output rp2y_pkg::pixel_t chroma_blue_o,
  output rp2y_pkg::pixel_t luma_second_o,
  output rp2y_pkg::pixel_t chroma_red_o,
  output logic             line_end_o
);

  rp2y_pkg::pixel_t luma_first_q, chroma_blue_q, luma_second_q, chroma_red_q;
  logic             line_end_q;

  // scale, clip and pack one yuyv word
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      luma_first_q  <= rp2y_pkg::to_byte(luma_first_sum_i, rp2y_pkg::LumaOffset);
      chroma_blue_q <= rp2y_pkg::to_byte(chroma_blue_sum_i, rp2y_pkg::ChromaOffset);
      luma_second_q <= rp2y_pkg::to_byte(luma_second_sum_i, rp2y_pkg::LumaOffset);
      chroma_red_q  <= rp2y_pkg::to_byte(chroma_red_sum_i, rp2y_pkg::ChromaOffset);
      line_end_q    <= line_end_i;
    end
  end

  assign luma_first_o  = luma_first_q;
  assign chroma_blue_o = chroma_blue_q;
  assign luma_second_o = luma_second_q;
  assign chroma_red_o  = chroma_red_q;
  assign line_end_o    = line_end_q;

endmodule

[rtl/rgb_pair_to_yuyv_unit.sv]
// rgb pair to yuyv 4:2:2 converter, bt.601 weights in q15
//
// input channel: valid_i / ready_o with one rgb pixel pair per request,
// plus an end-of-line flag that is carried along with the pair.
// output channel: valid_o / ready_i with one yuyv word per request:
// luma of both pixels, u from the first pixel, v from the second.
//
// two lanes, one per pixel, form the products in parallel; a merge stage
// adds, floors, offsets, clips and registers the word.
// an accepted pair is registered in the product stage, then in the output word register, which drives valid_o.
// throughput: one pair per cycle while ready_i is high; each of the two stages holds one request.
//
// reset clears both stage valid flags; no word is pending afterwards.
// when the receiver stalls, the output word holds; the product stage still
// takes one more pair, then ready_o drops until the output word is taken.
module rgb_pair_to_yuyv_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  rp2y_pkg::pixel_t blue_first_i,
  input  rp2y_pkg::pixel_t green_first_i,
  input  rp2y_pkg::pixel_t red_first_i,
  input  rp2y_pkg::pixel_t blue_second_i,
  input  rp2y_pkg::pixel_t green_second_i,
  input  rp2y_pkg::pixel_t red_second_i,
  input  logic             line_end_in_i,
  output logic             valid_o,
  input  logic             ready_i,
  output rp2y_pkg::pixel_t luma_first_o,
  output rp2y_pkg::pixel_t chroma_blue_o,
  output rp2y_pkg::pixel_t luma_second_o,
  output rp2y_pkg::pixel_t chroma_red_o,
  output logic             line_end_out_o
);

  logic prod_vld_q, prod_vld_d;
  logic out_vld_q, out_vld_d;
  logic line_end_q;
  logic prod_adv, in_fire;

  rp2y_pkg::sum_t luma_first_sum, chroma_blue_sum, luma_second_sum, chroma_red_sum;

  // stage handshake
  assign prod_adv = !out_vld_q || ready_i;
  assign ready_o  = !prod_vld_q || prod_adv;
  assign in_fire  = valid_i && ready_o;

  always_comb begin
    prod_vld_d = prod_vld_q;
    out_vld_d  = out_vld_q;
    if (ready_o) begin
      prod_vld_d = valid_i;
    end
    if (prod_adv) begin
      out_vld_d = prod_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      prod_vld_q <= prod_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // end-of-line flag alongside the products
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      line_end_q <= line_end_in_i;
    end
  end

  // lane for the first pixel: luma and u
  rp2y_lane u_lane_first (
    .clk_i        (clk_i),
    .en_i         (in_fire),
    .red_i        (red_first_i),
    .green_i      (green_first_i),
    .blue_i       (blue_first_i),
    .chroma_row_i (rp2y_pkg::URow),
    .luma_sum_o   (luma_first_sum),
    .chroma_sum_o (chroma_blue_sum)
  );

  // lane for the second pixel: luma and v
  rp2y_lane u_lane_second (
    .clk_i        (clk_i),
    .en_i         (in_fire),
    .red_i        (red_second_i),
    .green_i      (green_second_i),
    .blue_i       (blue_second_i),
    .chroma_row_i (rp2y_pkg::VRow),
    .luma_sum_o   (luma_second_sum),
    .chroma_sum_o (chroma_red_sum)
  );

  // output word register
  rp2y_merge u_merge (
    .clk_i             (clk_i),
    .en_i              (prod_adv && prod_vld_q),
    .luma_first_sum_i  (luma_first_sum),
    .chroma_blue_sum_i (chroma_blue_sum),
    .luma_second_sum_i (luma_second_sum),
    .chroma_red_sum_i  (chroma_red_sum),
    .line_end_i        (line_end_q),
    .luma_first_o      (luma_first_o),
    .chroma_blue_o     (chroma_blue_o),
    .luma_second_o     (luma_second_o),
    .chroma_red_o      (chroma_red_o),
    .line_end_o        (line_end_out_o)
  );

  assign valid_o = out_vld_q;

endmodule
